/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked out of reset
`define MSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property checked at every edge, reset included
`define MSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/msq_pkg.sv */
`timescale 1ns / 1ps

package msq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int TOKEN_COUNT = 4;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int TOK_W       = (TOKEN_COUNT > 1) ? $clog2(TOKEN_COUNT) : 1;
  localparam int RV_DEPTH    = QUEUE_DEPTH * TOKEN_COUNT;
  localparam int RV_AW       = (RV_DEPTH > 1) ? $clog2(RV_DEPTH) : 1;

  // datapath widths
  localparam int ADDR_W      = 64;
  localparam int DIV_CNT_W   = $clog2(ADDR_W + 1);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // status codes on the result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // function codes on the input
  typedef enum logic [2:0] {
    FN_CLEAR = 3'd0,
    FN_PUSH  = 3'd1,
    FN_POP   = 3'd2,
    FN_REL   = 3'd3,
    FN_ACQ   = 3'd4,
    FN_CHECK = 3'd5
  } func_e;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_PUSH,
    OP_POP,
    OP_REL,
    OP_ACQ,
    OP_CHK
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [TOK_W-1:0]  tok;
    logic [63:0]       base;
    logic [63:0]       stride;
    logic [63:0]       pc;
    logic [15:0]       rows;
    logic [15:0]       cols;
    logic [1:0]        esz;
    logic              tr;
    logic [63:0]       tval;
    logic [63:0]       lstart;
    logic [63:0]       lend;
  } cmd_t;

  typedef struct packed {
    logic        conflict;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic [1:0]  status;
    logic [63:0] head_base;
    logic [63:0] head_stride;
    logic [63:0] head_pc;
    logic [15:0] head_rows;
    logic [15:0] head_columns;
    logic [1:0]  head_elem_size;
    logic        head_transposed;
  } res_t;

  // back end sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_REL,
    S_ACQ_RD,
    S_ACQ_CMP,
    S_C_RD,
    S_C_LD,
    S_C_M0,
    S_C_M1,
    S_C_M2,
    S_C_M3,
    S_C_DIV,
    S_C_CHK,
    S_C_R0,
    S_C_R1,
    S_C_R2,
    S_C_R3,
    S_C_R4,
    S_FIN_RD,
    S_FIN_WR
  } state_e;

  // slot index of head plus offset, modulo the queue depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] h,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

/* hdl/msq_front.sv */
`timescale 1ns / 1ps

module msq_front import msq_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [63:0] base_addr_i,
  input  logic [63:0] row_stride_i,
  input  logic [15:0] rows_i,
  input  logic [15:0] columns_i,
  input  logic [1:0]  elem_size_log2_i,
  input  logic        transposed_i,
  input  logic [63:0] instr_pc_i,
  input  logic [1:0]  token_i,
  input  logic [63:0] token_value_i,
  input  logic [63:0] load_addr_i,
  input  logic [6:0]  load_len_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic tok_ok;

  assign tok_ok     = int'(token_i) < TOKEN_COUNT;
  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // classify the beat; unusable tokens turn token ops into no-ops
  always_comb begin
    cmd_o        = '0;
    cmd_o.tok    = TOK_W'(token_i);
    cmd_o.base   = base_addr_i;
    cmd_o.stride = row_stride_i;
    cmd_o.pc     = instr_pc_i;
    cmd_o.rows   = rows_i;
    cmd_o.cols   = columns_i;
    cmd_o.esz    = elem_size_log2_i;
    cmd_o.tr     = transposed_i;
    cmd_o.tval   = token_value_i;
    cmd_o.lstart = load_addr_i;
    cmd_o.lend   = load_addr_i + 64'(load_len_i) - 64'd1;
    case (func_e'(func_i))
      FN_CLEAR: cmd_o.op = OP_CLEAR;
      FN_PUSH:  cmd_o.op = OP_PUSH;
      FN_POP:   cmd_o.op = OP_POP;
      FN_REL:   cmd_o.op = tok_ok ? OP_REL : OP_NOP;
      FN_ACQ:   cmd_o.op = tok_ok ? OP_ACQ : OP_NOP;
      FN_CHECK: cmd_o.op = OP_CHK;
      default:  cmd_o.op = OP_NOP;
    endcase
  end

endmodule

/* hdl/msq_cmd_fifo.sv */
`timescale 1ns / 1ps

module msq_cmd_fifo import msq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o     = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];

  function automatic logic [FIFO_PTR_W-1:0] nxt(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* hdl/msq_div.sv */
`timescale 1ns / 1ps

// two restoring dividers sharing one divisor, one quotient bit per cycle
module msq_div import msq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] dvd_a_i,
  input  logic [ADDR_W-1:0] dvd_b_i,
  input  logic [ADDR_W-1:0] dvs_i,
  output logic              done_o,
  output logic [ADDR_W-1:0] quo_a_o,
  output logic [ADDR_W-1:0] quo_b_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ADDR_W-1:0]    dvs_q, rem_a_q, rem_b_q, quo_a_q, quo_b_q;
  logic [ADDR_W-1:0]    rem_a_d, rem_b_d;
  logic                 bit_a, bit_b;

  function automatic logic [ADDR_W:0] step(input logic [ADDR_W-1:0] rem,
                                           input logic              msb,
                                           input logic [ADDR_W-1:0] d);
    logic [ADDR_W:0] trial;
    trial = {rem, msb};
    if (trial >= {1'b0, d}) begin
      return {1'b1, ADDR_W'(trial - {1'b0, d})};
    end
    return {1'b0, trial[ADDR_W-1:0]};
  endfunction

  assign done_o  = busy_q && (cnt_q == '0);
  assign quo_a_o = quo_a_q;
  assign quo_b_o = quo_b_q;

  always_comb begin
    {bit_a, rem_a_d} = step(rem_a_q, quo_a_q[ADDR_W-1], dvs_q);
    {bit_b, rem_b_d} = step(rem_b_q, quo_b_q[ADDR_W-1], dvs_q);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(ADDR_W);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else             cnt_q  <= cnt_q - 1'b1;
    end
  end

  // shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q   <= dvs_i;
      rem_a_q <= '0;
      rem_b_q <= '0;
      quo_a_q <= dvd_a_i;
      quo_b_q <= dvd_b_i;
    end else if (busy_q && cnt_q != '0) begin
      rem_a_q <= rem_a_d;
      rem_b_q <= rem_b_d;
      quo_a_q <= {quo_a_q[ADDR_W-2:0], bit_a};
      quo_b_q <= {quo_b_q[ADDR_W-2:0], bit_b};
    end
  end

endmodule

/* hdl/msq_back.sv */
`timescale 1ns / 1ps

module msq_back import msq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  state_e state_q, state_d;
  cmd_t   cmd_q;

  logic [PTR_W-1:0]       head_q;
  logic [CNT_W-1:0]       cnt_q, idx_q;
  logic [TOKEN_COUNT-1:0] rvalid_q [QUEUE_DEPTH];
  logic                   out_valid_q;
  res_t                   res_q;
  logic [1:0]             status_q;
  logic                   conflict_q;

  // entry stores and release values
  logic [63:0] ent_base_m   [QUEUE_DEPTH];
  logic [63:0] ent_stride_m [QUEUE_DEPTH];
  logic [63:0] ent_pc_m     [QUEUE_DEPTH];
  logic [34:0] ent_shape_m  [QUEUE_DEPTH];
  logic [63:0] rel_m        [RV_DEPTH];
  logic [63:0] base_rd, stride_rd, pc_rd, rel_rd;
  logic [34:0] shape_rd;

  // conflict working registers
  logic [63:0] base_q, stride_q, acc_q, prod_q, rs_q;
  logic [15:0] mrows_q, mcols_q;
  logic [1:0]  esz_q;
  logic [31:0] srow_q, erow_q;

  // control strobes
  logic             ent_we, rel_we, div_start;
  logic [PTR_W-1:0] ent_ra;
  logic [RV_AW-1:0] rel_wa, rel_ra;
  logic [31:0]      mul_a, mul_b;

  logic [PTR_W-1:0] tail_slot, walk_slot, rel_slot, head_nxt;
  logic             full, rel_bit, head_bit, span_miss, rows_hit, row_hit, go_out;
  logic [63:0]      span_end, row_end;
  logic [18:0]      row_bytes_m1;
  logic             div_done;
  logic [63:0]      quo_a, quo_b;

  function automatic logic [RV_AW-1:0] rv_addr(input logic [PTR_W-1:0] slot,
                                               input logic [TOK_W-1:0] tok);
    return RV_AW'(int'(slot) * TOKEN_COUNT + int'(tok));
  endfunction

  assign tail_slot = wrap_add(head_q, cnt_q);
  assign walk_slot = wrap_add(head_q, idx_q);
  assign rel_slot  = wrap_add(head_q, idx_q - 1'b1);
  assign head_nxt  = wrap_add(head_q, CNT_W'(1));
  assign full      = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign rel_bit   = rvalid_q[rel_slot][cmd_q.tok];
  assign head_bit  = rvalid_q[head_q][cmd_q.tok];
  assign go_out    = !out_valid_q || res_ready_i;

  // range tests of the conflict walk
  assign span_end     = base_q + acc_q;
  assign span_miss    = cmd_q.lend < base_q || cmd_q.lstart >= span_end ||
                        mrows_q == '0 || mcols_q == '0;
  assign rows_hit     = erow_q != srow_q && erow_q < 32'(mrows_q);
  assign row_bytes_m1 = (19'(mcols_q) << esz_q) - 19'd1;
  assign row_end      = rs_q + 64'(row_bytes_m1);
  assign row_hit      = !(cmd_q.lend < rs_q || cmd_q.lstart > row_end);

  msq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_a_i (cmd_q.lstart - base_q),
    .dvd_b_i (cmd_q.lend - base_q),
    .dvs_i   (stride_q),
    .done_o  (div_done),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_REL:  state_d = S_REL;
            OP_ACQ:  state_d = S_ACQ_RD;
            OP_CHK:  state_d = S_C_RD;
            default: state_d = S_EXEC;
          endcase
        end
      end
      S_EXEC:    state_d = S_FIN_RD;
      S_REL:     if (idx_q == '0 || rel_bit) state_d = S_FIN_RD;
      S_ACQ_RD:  state_d = (cnt_q == '0 || !head_bit) ? S_FIN_RD : S_ACQ_CMP;
      S_ACQ_CMP: state_d = (rel_rd <= cmd_q.tval) ? S_ACQ_RD : S_FIN_RD;
      S_C_RD:    state_d = (idx_q == cnt_q) ? S_FIN_RD : S_C_LD;
      S_C_LD:    state_d = (stride_rd == '0) ? S_C_RD : S_C_M0;
      S_C_M0:    state_d = S_C_M1;
      S_C_M1:    state_d = S_C_M2;
      S_C_M2:    state_d = S_C_M3;
      S_C_M3:    state_d = span_miss ? S_C_RD : S_C_DIV;
      S_C_DIV:   if (div_done) state_d = S_C_CHK;
      S_C_CHK:   state_d = rows_hit ? S_FIN_RD : S_C_R0;
      S_C_R0:    state_d = S_C_R1;
      S_C_R1:    state_d = S_C_R2;
      S_C_R2:    state_d = S_C_R3;
      S_C_R3:    state_d = S_C_R4;
      S_C_R4:    state_d = row_hit ? S_FIN_RD : S_C_RD;
      S_FIN_RD:  state_d = S_FIN_WR;
      S_FIN_WR:  if (go_out) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    cmd_pop_o = 1'b0;
    ent_we    = 1'b0;
    rel_we    = 1'b0;
    div_start = 1'b0;
    ent_ra    = head_q;
    rel_wa    = rv_addr(rel_slot, cmd_q.tok);
    rel_ra    = rv_addr(head_q, cmd_q.tok);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      S_IDLE:  cmd_pop_o = cmd_valid_i;
      S_EXEC:  ent_we    = cmd_q.op == OP_PUSH && !full;
      S_REL:   rel_we    = idx_q != '0 && !rel_bit;
      S_C_RD:  ent_ra    = walk_slot;
      S_C_M0: begin
        mul_a = 32'(mrows_q);
        mul_b = stride_q[31:0];
      end
      S_C_M1: begin
        mul_a = 32'(mrows_q);
        mul_b = stride_q[63:32];
      end
      S_C_M3:  div_start = !span_miss;
      S_C_R0: begin
        mul_a = srow_q;
        mul_b = stride_q[31:0];
      end
      S_C_R1: begin
        mul_a = srow_q;
        mul_b = stride_q[63:32];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) rvalid_q[i] <= '0;
    end else begin
      state_q <= state_d;
      // result register handshake
      if (state_q == S_FIN_WR && go_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) idx_q <= (cmd_i.op == OP_REL) ? cnt_q : '0;
        S_EXEC: begin
          case (cmd_q.op)
            OP_CLEAR: begin
              head_q <= '0;
              cnt_q  <= '0;
            end
            OP_PUSH: begin
              if (!full) begin
                rvalid_q[tail_slot] <= '0;
                cnt_q <= cnt_q + 1'b1;
              end
            end
            OP_POP: begin
              if (cnt_q != '0) begin
                head_q <= head_nxt;
                cnt_q  <= cnt_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_REL: begin
          if (idx_q != '0 && !rel_bit) begin
            rvalid_q[rel_slot][cmd_q.tok] <= 1'b1;
            idx_q <= idx_q - 1'b1;
          end
        end
        S_ACQ_CMP: begin
          if (rel_rd <= cmd_q.tval) begin
            head_q <= head_nxt;
            cnt_q  <= cnt_q - 1'b1;
          end
        end
        S_C_LD: if (stride_rd == '0) idx_q <= idx_q + 1'b1;
        S_C_M3: if (span_miss) idx_q <= idx_q + 1'b1;
        S_C_R4: if (!row_hit) idx_q <= idx_q + 1'b1;
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q      <= cmd_i;
          status_q   <= ST_OK;
          conflict_q <= 1'b0;
        end
      end
      S_EXEC: begin
        if (cmd_q.op == OP_PUSH && full)       status_q <= ST_FULL;
        if (cmd_q.op == OP_POP && cnt_q == '0) status_q <= ST_EMPTY;
      end
      S_C_LD: begin
        base_q   <= base_rd;
        stride_q <= stride_rd;
        mrows_q  <= shape_rd[34] ? shape_rd[31:16] : shape_rd[15:0];
        mcols_q  <= shape_rd[34] ? shape_rd[15:0] : shape_rd[31:16];
        esz_q    <= shape_rd[33:32];
      end
      S_C_M1, S_C_R1: acc_q <= prod_q;
      S_C_M2, S_C_R2: acc_q <= acc_q + {prod_q[31:0], 32'h0};
      S_C_DIV: begin
        if (div_done) begin
          srow_q <= quo_a[31:0];
          erow_q <= quo_b[31:0];
        end
      end
      S_C_CHK: if (rows_hit) conflict_q <= 1'b1;
      S_C_R3:  rs_q <= base_q + acc_q;
      S_C_R4:  if (row_hit) conflict_q <= 1'b1;
      S_FIN_WR: begin
        if (go_out) begin
          res_q.conflict        <= conflict_q;
          res_q.occupancy       <= 5'(cnt_q);
          res_q.is_empty        <= cnt_q == '0;
          res_q.status          <= status_q;
          res_q.head_base       <= (cnt_q != '0) ? base_rd : '0;
          res_q.head_stride     <= (cnt_q != '0) ? stride_rd : '0;
          res_q.head_pc         <= (cnt_q != '0) ? pc_rd : '0;
          res_q.head_rows       <= (cnt_q != '0) ? shape_rd[15:0] : '0;
          res_q.head_columns    <= (cnt_q != '0) ? shape_rd[31:16] : '0;
          res_q.head_elem_size  <= (cnt_q != '0) ? shape_rd[33:32] : '0;
          res_q.head_transposed <= (cnt_q != '0) && shape_rd[34];
        end
      end
      default: ;
    endcase
  end

  // entry memories, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_base_m[tail_slot]   <= cmd_q.base;
      ent_stride_m[tail_slot] <= cmd_q.stride;
      ent_pc_m[tail_slot]     <= cmd_q.pc;
      ent_shape_m[tail_slot]  <= {cmd_q.tr, cmd_q.esz, cmd_q.cols, cmd_q.rows};
    end
    base_rd   <= ent_base_m[ent_ra];
    stride_rd <= ent_stride_m[ent_ra];
    pc_rd     <= ent_pc_m[ent_ra];
    shape_rd  <= ent_shape_m[ent_ra];
  end

  // release value memory
  always_ff @(posedge clk_i) begin
    if (rel_we) rel_m[rel_wa] <= cmd_q.tval;
    rel_rd <= rel_m[rel_ra];
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* hdl/matrix_store_queue_conflict_top.sv */
// Queue of up to 16 pending matrix stores with sync-token release tags and a
// load conflict check. Beats enter through a two-deep command queue, so the
// input keeps taking beats while the back end works and while a result waits
// on the output register, until that queue fills. Each beat gives exactly
// one result, describing the queue after the operation. Release tag visits
// each entry it tags, newest first; acquire removes entries from the head
// and stops on an untagged entry or on a tagged entry whose value is above
// the threshold. The conflict check walks the live entries oldest first: it
// passes over an entry with zero stride, one outside the load range and one
// with an empty shape; any other entry needs the row indices, whose two
// 64-bit quotients come from a shared bit-serial divider at one bit per
// cycle, and may give a hit on the rows alone; the walk stops at the first
// hit.
`timescale 1ns / 1ps

module matrix_store_queue_conflict_top import msq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [63:0] base_addr_i,
  input  logic [63:0] row_stride_i,
  input  logic [15:0] rows_i,
  input  logic [15:0] columns_i,
  input  logic [1:0]  elem_size_log2_i,
  input  logic        transposed_i,
  input  logic [63:0] instr_pc_i,
  input  logic [1:0]  token_i,
  input  logic [63:0] token_value_i,
  input  logic [63:0] load_addr_i,
  input  logic [6:0]  load_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        conflict_o,
  output logic [4:0]  occupancy_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o,
  output logic [63:0] head_base_o,
  output logic [63:0] head_stride_o,
  output logic [63:0] head_pc_o,
  output logic [15:0] head_rows_o,
  output logic [15:0] head_columns_o,
  output logic [1:0]  head_elem_size_o,
  output logic        head_transposed_o
);

  logic fifo_full, fifo_push, fifo_valid, fifo_pop;
  cmd_t front_cmd, back_cmd;
  res_t res;

  msq_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .base_addr_i      (base_addr_i),
    .row_stride_i     (row_stride_i),
    .rows_i           (rows_i),
    .columns_i        (columns_i),
    .elem_size_log2_i (elem_size_log2_i),
    .transposed_i     (transposed_i),
    .instr_pc_i       (instr_pc_i),
    .token_i          (token_i),
    .token_value_i    (token_value_i),
    .load_addr_i      (load_addr_i),
    .load_len_i       (load_len_i),
    .fifo_full_i      (fifo_full),
    .push_o           (fifo_push),
    .cmd_o            (front_cmd)
  );

  msq_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (front_cmd),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (back_cmd)
  );

  msq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (fifo_pop),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  // result fields
  assign conflict_o        = res.conflict;
  assign occupancy_o       = res.occupancy;
  assign is_empty_o        = res.is_empty;
  assign status_o          = res.status;
  assign head_base_o       = res.head_base;
  assign head_stride_o     = res.head_stride;
  assign head_pc_o         = res.head_pc;
  assign head_rows_o       = res.head_rows;
  assign head_columns_o    = res.head_columns;
  assign head_elem_size_o  = res.head_elem_size;
  assign head_transposed_o = res.head_transposed;

endmodule

/* hdl/msq_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msq_checker import msq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  occupancy_o,
  input logic        is_empty_o,
  input logic [1:0]  status_o,
  input logic [63:0] head_base_o,
  input logic [15:0] head_rows_o
);

  // a result beat waits until taken
  `MSQ_ASSERT(a_out_hold, (out_valid_o && !out_ready_i |=> out_valid_o), "result beat dropped")

  // no result during reset
  `MSQ_ASSERT_ALWAYS(a_rst_quiet, (!rst_ni |-> !out_valid_o), "result during reset")

  // empty flag agrees with the count, and an empty queue shows a zero head
  `MSQ_ASSERT(a_empty_cnt, (out_valid_o |-> (is_empty_o == (occupancy_o == 5'd0))), "empty flag wrong")
  `MSQ_ASSERT(a_empty_head, (out_valid_o && is_empty_o |-> head_base_o == '0 && head_rows_o == '0), "head not cleared")

  // a dropped push only happens with the queue full
  `MSQ_ASSERT(a_full_cnt, (out_valid_o && status_o == ST_FULL |-> occupancy_o == 5'(QUEUE_DEPTH)), "full status with room left")

endmodule

bind matrix_store_queue_conflict_top msq_checker u_msq_checker (.*);
